// ===== src/bts_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants for the bilinear texel sampler: field widths, stream layout,
// register indexes and command codes. No dependencies.
package bts_pkg;

  localparam int COORD_W    = 24;
  localparam int CHAN_W     = 8;
  localparam int NUM_CH     = 4;
  localparam int OUT_W      = 24;
  localparam int ADDR_IN_W  = 12;
  localparam int TEXEL_W    = CHAN_W * NUM_CH;
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = OUT_W * NUM_CH;
  localparam int CFG_REG_W  = 7;

  localparam logic [CFG_REG_W-1:0] SIDE_RESET = 7'd64;
  localparam logic [OUT_W-1:0]     OUT_MAX    = 24'hFF0000;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

endpackage

// ===== src/bts_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/bilinear_texel_sampler_wrap.sv =====
`timescale 1ns / 1ps
// A sample word passes down the pipeline to the output; a write word updates the texel store
// as it moves on from stage 6 and returns nothing.
// Throughput: one word per cycle while the output side is not stalled; the modulo walk for wrap addressing spans
// three stages and four RAM copies give the four texel reads of each sample.
// Reset (rst, synchronous): empties the pipeline and sets width and height to 64.
// Texel store contents are not cleared. Uses bts_pkg and bts_ram.
module bilinear_texel_sampler_wrap
  import bts_pkg::*;
#(
  parameter int TEXEL_COUNT = 4096,
  parameter int MAX_SIDE    = 64,
  parameter int FRAC_BITS   = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [11:0] texel_address, [19:12] texel_red, [27:20] texel_green,
  // [35:28] texel_blue, [43:36] texel_alpha, [67:44] sample_u, [91:68] sample_v
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // [0] cmd
  input  logic [0:0]            s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [23:0] out_red, [47:24] out_green, [71:48] out_blue, [95:72] out_alpha
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int IB    = COORD_W - FRAC_BITS;
  localparam int NSTEP = IB - 1;
  localparam int SPS   = (NSTEP + 2) / 3;
  localparam int SW    = $clog2(MAX_SIDE + 1);
  localparam int AW    = (TEXEL_COUNT > 1) ? $clog2(TEXEL_COUNT) : 1;
  localparam int PW    = 2 * SW;
  localparam int SUMW  = (PW + 1 > AW) ? PW + 1 : AW;
  localparam int FW1   = FRAC_BITS + 1;
  localparam int TW    = CHAN_W + FRAC_BITS;
  localparam int TW1   = TW + 1;
  localparam int VW    = CHAN_W + 2 * FRAC_BITS;
  localparam int VW1   = VW + 1;
  localparam int XW    = VW + 17;
  localparam int DN    = (2 * FRAC_BITS > 16) ? 2 * FRAC_BITS - 16 : 1;
  localparam int UP    = (2 * FRAC_BITS > 16) ? 0 : 16 - 2 * FRAC_BITS;
  localparam int NST   = 9;

  typedef struct packed {
    logic                 cmd;
    logic                 wok;
    logic [AW-1:0]        waddr;
    logic [TEXEL_W-1:0]   wdata;
    logic [FRAC_BITS-1:0] fu;
    logic [FRAC_BITS-1:0] fv;
  } meta_t;

  typedef struct packed {
    logic [IB-1:0] x;
    logic [IB-1:0] y;
    logic [SW-1:0] rx;
    logic [SW-1:0] ry;
  } crd_t;

  // configuration
  logic [CFG_REG_W-1:0] tex_width;
  logic [CFG_REG_W-1:0] tex_height;
  logic [SW-1:0]        w_eff;
  logic [SW-1:0]        h_eff;

  // pipeline control
  logic [NST:1] v;
  logic [NST:1] en;

  // pipeline payload
  meta_t             meta [1:6];
  crd_t              crd  [1:4];
  crd_t              crd_next [0:2];
  crd_t              crd_in;
  meta_t             meta_in;
  logic [SW-1:0]     c0, c1;
  logic [PW-1:0]     p0, p1;
  logic [SW-1:0]     c1_next, r1_next;
  logic [SW:0]       c1_inc, r1_inc;
  logic [AW-1:0]     addr [4];
  logic [AW-1:0]     addr_next [4];
  logic [TEXEL_W-1:0] texel [4];
  logic              ram_we;
  logic [FRAC_BITS-1:0] fu7, fv7, fv8;
  logic [TW-1:0]     top [NUM_CH];
  logic [TW-1:0]     bot [NUM_CH];
  logic [NUM_CH-1:0][OUT_W-1:0] ores;
  logic [NUM_CH-1:0][OUT_W-1:0] ores_next;

  function automatic logic [SW-1:0] mod_step(input logic [SW-1:0] r, input logic b,
                                             input logic [SW-1:0] m);
    logic [SW:0] t;
    t = {r, b};
    if (t >= {1'b0, m}) begin
      t = t - {1'b0, m};
    end
    return t[SW-1:0];
  endfunction

  // APB register file
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tex_width  <= SIDE_RESET;
      tex_height <= SIDE_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_WIDTH:  tex_width  <= pwdata[CFG_REG_W-1:0];
        REG_HEIGHT: tex_height <= pwdata[CFG_REG_W-1:0];
        default: ;
      endcase
    end
  end

  assign prdata = (paddr[2] == REG_HEIGHT) ? {25'b0, tex_height} : {25'b0, tex_width};

  always_comb begin
    if (tex_width == '0) begin
      w_eff = SW'(1);
    end else if (int'(tex_width) > MAX_SIDE) begin
      w_eff = SW'(MAX_SIDE);
    end else begin
      w_eff = SW'(tex_width);
    end
    if (tex_height == '0) begin
      h_eff = SW'(1);
    end else if (int'(tex_height) > MAX_SIDE) begin
      h_eff = SW'(MAX_SIDE);
    end else begin
      h_eff = SW'(tex_height);
    end
  end

  // stage enables: a stage loads when empty or when the next one moves
  always_comb begin
    en[NST] = !v[NST] || m_tready;
    for (int k = NST - 1; k >= 1; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign s_tready = en[1];
  assign m_tvalid = v[NST];
  assign m_tdata  = ores;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) v[1] <= s_tvalid;
      for (int k = 2; k <= NST; k++) begin
        if (en[k]) begin
          if (k == 7) begin
            v[k] <= v[k-1] && (meta[6].cmd == CMD_SAMPLE);
          end else begin
            v[k] <= v[k-1];
          end
        end
      end
    end
  end

  // input decode: floor coordinates, seed remainder with the sign weight
  always_comb begin
    meta_in.cmd   = s_tuser[0];
    meta_in.wok   = 32'(s_tdata[11:0]) < 32'(TEXEL_COUNT);
    meta_in.waddr = AW'(s_tdata[11:0]);
    meta_in.wdata = s_tdata[43:12];
    meta_in.fu    = s_tdata[44 +: FRAC_BITS];
    meta_in.fv    = s_tdata[68 +: FRAC_BITS];
    crd_in.x      = s_tdata[67 -: IB];
    crd_in.y      = s_tdata[91 -: IB];
    crd_in.rx     = crd_in.x[IB-1] ? w_eff - SW'(1) : '0;
    crd_in.ry     = crd_in.y[IB-1] ? h_eff - SW'(1) : '0;
  end

  // modulo walk, one coordinate bit per step
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      crd_next[k] = crd[k+1];
      for (int j = 0; j < SPS; j++) begin
        if (IB - 2 - (k * SPS + j) >= 0) begin
          crd_next[k].rx = mod_step(crd_next[k].rx, crd[k+1].x[IB-2-(k*SPS+j)], w_eff);
          crd_next[k].ry = mod_step(crd_next[k].ry, crd[k+1].y[IB-2-(k*SPS+j)], h_eff);
        end
      end
    end
  end

  always_comb begin
    c1_inc  = {1'b0, crd[4].rx} + (SW+1)'(1);
    r1_inc  = {1'b0, crd[4].ry} + (SW+1)'(1);
    c1_next = (c1_inc == {1'b0, w_eff}) ? '0 : c1_inc[SW-1:0];
    r1_next = (r1_inc == {1'b0, h_eff}) ? '0 : r1_inc[SW-1:0];
  end

  always_comb begin
    addr_next[0] = AW'(SUMW'(p0) + SUMW'(c0));
    addr_next[1] = AW'(SUMW'(p1) + SUMW'(c0));
    addr_next[2] = AW'(SUMW'(p0) + SUMW'(c1));
    addr_next[3] = AW'(SUMW'(p1) + SUMW'(c1));
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      meta[1] <= meta_in;
      crd[1]  <= crd_in;
    end
    for (int k = 2; k <= 4; k++) begin
      if (en[k]) begin
        meta[k] <= meta[k-1];
        crd[k]  <= crd_next[k-2];
      end
    end
    if (en[5]) begin
      meta[5] <= meta[4];
      c0      <= crd[4].rx;
      c1      <= c1_next;
      p0      <= PW'(crd[4].ry) * PW'(w_eff);
      p1      <= PW'(r1_next) * PW'(w_eff);
    end
    if (en[6]) begin
      meta[6] <= meta[5];
      for (int q = 0; q < 4; q++) begin
        addr[q] <= addr_next[q];
      end
    end
    if (en[7]) begin
      fu7 <= meta[6].fu;
      fv7 <= meta[6].fv;
    end
    if (en[8]) begin
      fv8 <= fv7;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        top[ch] <= TW'(TW1'({1'b1, {FRAC_BITS{1'b0}}} - FW1'(fu7)) * TW1'(texel[0][ch*CHAN_W +: CHAN_W])
                     + TW1'(fu7) * TW1'(texel[2][ch*CHAN_W +: CHAN_W]));
        bot[ch] <= TW'(TW1'({1'b1, {FRAC_BITS{1'b0}}} - FW1'(fu7)) * TW1'(texel[1][ch*CHAN_W +: CHAN_W])
                     + TW1'(fu7) * TW1'(texel[3][ch*CHAN_W +: CHAN_W]));
      end
    end
    if (en[9]) begin
      ores <= ores_next;
    end
  end

  // texel reads: four copies of the store, each written by every in-range write word
  assign ram_we = en[7] && v[6] && (meta[6].cmd == CMD_WRITE) && meta[6].wok;

  for (genvar q = 0; q < 4; q++) begin : g_bank
    bts_ram #(
      .WIDTH(TEXEL_W),
      .DEPTH(TEXEL_COUNT)
    ) u_ram (
      .clk   (clk),
      .we    (ram_we),
      .waddr (meta[6].waddr),
      .wdata (meta[6].wdata),
      .re    (en[7]),
      .raddr (addr[q]),
      .rdata (texel[q])
    );
  end

  // vertical blend and scale to 16 fraction bits
  always_comb begin
    logic [VW1-1:0] val;
    logic [XW-1:0]  t;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      val = VW1'(FW1'({1'b1, {FRAC_BITS{1'b0}}}) - FW1'(fv8)) * VW1'(top[ch])
          + VW1'(fv8) * VW1'(bot[ch]);
      if (2 * FRAC_BITS > 16) begin
        t = (XW'(val) + (XW'(1) << (DN - 1))) >> DN;
      end else begin
        t = XW'(val) << UP;
      end
      ores_next[ch] = t[OUT_W-1:0];
    end
  end

endmodule

// ===== src/bts_check.sv =====
`timescale 1ns / 1ps
// Port-level checks for the bilinear texel sampler, bound to its top level.
// Uses bts_pkg.
module bts_check
  import bts_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic [IN_DATA_W-1:0]  s_tdata,
  input logic [0:0]            s_tuser,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic                  psel,
  input logic                  penable,
  input logic                  pwrite,
  input logic [2:0]            paddr,
  input logic [31:0]           pwdata,
  input logic [31:0]           prdata,
  input logic                  pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result word valid right after reset");

  a_no_block: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid || m_tready |-> s_tready)
    else $error("input stalled while output side is free");

  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[23:0] <= OUT_MAX && m_tdata[47:24] <= OUT_MAX
              && m_tdata[71:48] <= OUT_MAX && m_tdata[95:72] <= OUT_MAX)
    else $error("blended channel above full scale");

endmodule

bind bilinear_texel_sampler_wrap bts_check u_check (.*);

// ===== verif/tb_bilinear_texel_sampler_wrap.sv =====
`timescale 1ns / 1ps
// Self-checking bench for bilinear_texel_sampler_wrap: texel writes, wrapped bilinear
// samples and APB size registers, checked against a predictor kept inside the bench.
// Depends on bts_pkg and the sampler RTL.
module tb_bilinear_texel_sampler_wrap;
  import bts_pkg::*;

  localparam int STORE_DEPTH = 4096;
  localparam int SIDE_MAX    = 64;
  localparam int FILL_COUNT  = 512;
  localparam int IDLE_LIMIT  = 4000;
  localparam int DRAIN_WAIT  = 24;

  typedef struct {
    logic                 cmd;
    logic [ADDR_IN_W-1:0] addr;
    logic [CHAN_W-1:0]    chan [NUM_CH];
    logic [COORD_W-1:0]   u;
    logic [COORD_W-1:0]   v;
  } texel_word_t;

  typedef struct {
    logic [OUT_W-1:0] chan [NUM_CH];
  } color_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [0:0]            s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [2:0]            paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  bilinear_texel_sampler_wrap dut (.*);

  always #1 clk = ~clk;

  logic [TEXEL_W-1:0] texel_mirror [STORE_DEPTH];
  logic [CFG_REG_W-1:0] width_reg = SIDE_RESET;
  logic [CFG_REG_W-1:0] height_reg = SIDE_RESET;
  texel_word_t pending_words [$];
  color_t      expected_colors [$];
  texel_word_t cur_word;
  int gap_left = 0;
  int burst_left = 0;
  int errors = 0;
  int samples_seen = 0;
  int writes_sent = 0;
  int idle_cycles = 0;
  int cycle_count = 0;
  int stall_mode = 0;

  function automatic longint side_of(logic [CFG_REG_W-1:0] r);
    if (r == 0) return 1;
    if (r > SIDE_MAX) return SIDE_MAX;
    return longint'(r);
  endfunction

  function automatic longint wrap_index(longint a, longint m);
    longint r;
    r = a % m;
    if (r < 0) r += m;
    return r;
  endfunction

  function automatic color_t blend_sample(logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
    color_t res;
    longint w, h, su, sv, fu, fv, x, y, c0, c1, r0, r1;
    logic [TEXEL_W-1:0] q11, q12, q21, q22;
    longint a11, a12, a21, a22, top, bot, val;
    w = side_of(width_reg);
    h = side_of(height_reg);
    su = longint'($signed(u));
    sv = longint'($signed(v));
    fu = su & 255;
    fv = sv & 255;
    x = su >>> 8;
    y = sv >>> 8;
    c0 = wrap_index(x, w);
    c1 = wrap_index(x + 1, w);
    r0 = wrap_index(y, h);
    r1 = wrap_index(y + 1, h);
    q11 = texel_mirror[(r0 * w + c0) % STORE_DEPTH];
    q12 = texel_mirror[(r1 * w + c0) % STORE_DEPTH];
    q21 = texel_mirror[(r0 * w + c1) % STORE_DEPTH];
    q22 = texel_mirror[(r1 * w + c1) % STORE_DEPTH];
    for (int ch = 0; ch < NUM_CH; ch++) begin
      a11 = longint'(q11[ch*8 +: 8]);
      a12 = longint'(q12[ch*8 +: 8]);
      a21 = longint'(q21[ch*8 +: 8]);
      a22 = longint'(q22[ch*8 +: 8]);
      top = (256 - fu) * a11 + fu * a21;
      bot = (256 - fu) * a12 + fu * a22;
      val = (256 - fv) * top + fv * bot;
      res.chan[ch] = val[OUT_W-1:0];
    end
    return res;
  endfunction

  function automatic logic [CHAN_W-1:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return CHAN_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_write(int addr);
    texel_word_t t;
    t.cmd = CMD_WRITE;
    t.addr = ADDR_IN_W'(addr);
    for (int ch = 0; ch < NUM_CH; ch++) t.chan[ch] = rand_byte();
    t.u = COORD_W'($urandom);
    t.v = COORD_W'($urandom);
    pending_words.push_back(t);
  endtask

  task automatic push_sample(logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
    texel_word_t t;
    t.cmd = CMD_SAMPLE;
    t.addr = ADDR_IN_W'($urandom);
    for (int ch = 0; ch < NUM_CH; ch++) t.chan[ch] = CHAN_W'($urandom);
    t.u = u;
    t.v = v;
    pending_words.push_back(t);
  endtask

  function automatic logic [COORD_W-1:0] rand_coord();
    int span;
    span = 2 * SIDE_MAX * 256;
    case ($urandom_range(0, 5))
      0: return COORD_W'($urandom);
      1: return COORD_W'(24'h800000 + $urandom_range(0, 2000));
      2: return COORD_W'(24'h7FFFFF - $urandom_range(0, 2000));
      default: return COORD_W'($urandom_range(0, 2 * span) - span);
    endcase
  endfunction

  // Apply each accepted word to the mirror and queue the blended color.
  always @(posedge clk) begin
    int send;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        idle_cycles = 0;
        if (cur_word.cmd == CMD_WRITE) begin
          writes_sent++;
          texel_mirror[cur_word.addr] = {cur_word.chan[3], cur_word.chan[2],
                                         cur_word.chan[1], cur_word.chan[0]};
        end else begin
          expected_colors.push_back(blend_sample(cur_word.u, cur_word.v));
        end
      end
      if (!(s_tvalid && !s_tready)) begin
        send = 0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_words.size() > 0) begin
          cur_word = pending_words.pop_front();
          s_tdata <= {4'b0, cur_word.v, cur_word.u, cur_word.chan[3], cur_word.chan[2],
                      cur_word.chan[1], cur_word.chan[0], cur_word.addr};
          s_tuser <= cur_word.cmd;
          send = 1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
        s_tvalid <= send[0];
      end
    end
  end

  // Check each result word and stall the result side on a randomly changing pattern.
  always @(posedge clk) begin
    color_t exp_c;
    logic [OUT_W-1:0] got;
    cycle_count++;
    if (cycle_count % 64 == 0) stall_mode = $urandom_range(0, 2);
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        idle_cycles = 0;
        samples_seen++;
        if (expected_colors.size() == 0) begin
          errors++;
          $display("%0t: unexpected color word, expected none, got %h", $time, m_tdata);
        end else begin
          exp_c = expected_colors.pop_front();
          for (int ch = 0; ch < NUM_CH; ch++) begin
            got = m_tdata[ch*OUT_W +: OUT_W];
            if (got !== exp_c.chan[ch]) begin
              errors++;
              $display("%0t: channel %0d mismatch, expected %h, got %h",
                       $time, ch, exp_c.chan[ch], got);
            end
          end
        end
      end
      case (stall_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 1) == 1);
        default: m_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    idle_cycles++;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  task automatic reg_write(logic idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    idle_cycles = 0;
    if (idx == REG_WIDTH) width_reg = val[CFG_REG_W-1:0];
    else height_reg = val[CFG_REG_W-1:0];
  endtask

  task automatic drain();
    @(negedge clk);
    while (pending_words.size() > 0 || s_tvalid || expected_colors.size() > 0)
      @(negedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 3) push_write($urandom_range(0, STORE_DEPTH - 1));
      else push_sample(rand_coord(), rand_coord());
    end
    drain();
  endtask

  initial begin
    int sizes [8][2];
    int wr;
    int hmax;
    sizes = '{'{1, 1}, '{0, 0}, '{127, 1}, '{1, 127},
              '{3, 5}, '{65, 2}, '{64, 8}, '{127, 8}};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    // Keep width times height within the filled texels so no sample reads an unwritten one.
    reg_write(REG_WIDTH, 64);
    reg_write(REG_HEIGHT, 8);
    for (int a = 0; a < FILL_COUNT; a++) push_write(a);
    push_sample(24'h000000, 24'h000000);
    push_sample(24'h7FFFFF, 24'h7FFFFF);
    push_sample(24'h800000, 24'h800000);
    push_sample(24'hFFFFFF, 24'hFFFFFF);
    push_sample(24'h0000FF, 24'h000080);
    push_sample(24'h003F80, 24'h003FFF);
    push_sample(24'hFFFF01, 24'h7FFF00);
    push_sample(24'h800000, 24'h7FFFFF);
    push_write(0);
    push_sample(24'hFFFF80, 24'hFFFF80);
    drain();
    for (int p = 0; p < 8; p++) begin
      reg_write(REG_WIDTH, sizes[p][0]);
      reg_write(REG_HEIGHT, sizes[p][1]);
      random_phase(80);
    end
    wr = $urandom_range(0, 127);
    hmax = FILL_COUNT / int'(side_of(CFG_REG_W'(wr)));
    reg_write(REG_WIDTH, wr);
    reg_write(REG_HEIGHT, $urandom_range(0, hmax));
    random_phase(100);
    $display("covered %0d texel writes and %0d checked samples over 10 size settings",
             writes_sent, samples_seen);
    $display("sizes included zero, one, the maximum and oversize values");
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
